FILE: rtl/bmp565_pkg.sv
`timescale 1ns / 1ps

package bmp565_pkg;

    typedef enum logic [1:0] {
        FMT_RGB16       = 2'd0,
        FMT_RGB16_ALPHA = 2'd1,
        FMT_BGR24       = 2'd2,
        FMT_BGRA32      = 2'd3
    } pixel_format_t;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT  = 2'd0,
        REG_ROW_WIDTH     = 2'd1,
        REG_PAD_BYTES     = 2'd2,
        REG_MASKING_COLOR = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W  = 16;
    localparam int ROW_WIDTH_W = 11;

    localparam pixel_format_t PIXEL_FORMAT_RESET  = FMT_BGR24;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd320;
    localparam logic [1:0]  PAD_BYTES_RESET       = 2'd0;
    localparam logic [15:0] MASKING_COLOR_RESET   = 16'h0000;

    // lowest green bit of an RGB565 word
    localparam logic [15:0] GREEN_LSB = 16'h0020;

endpackage

FILE: rtl/bmp565_byte_if.sv
`timescale 1ns / 1ps

interface bmp565_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/bmp565_pixel_if.sv
`timescale 1ns / 1ps

interface bmp565_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        row_end;

    modport source (output valid, output pixel, output row_end, input ready);
    modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

FILE: rtl/bmp_row_to_rgb565_converter_core.sv
`timescale 1ns / 1ps

// Bitmap row to RGB565 converter. Takes one byte per cycle on the byte channel and
// gives one RGB565 word on the pixel channel for each completed pixel (2, 3 or 4
// bytes by format); row filler bytes are dropped. A byte goes into an input
// register and is converted and counted on its way into the result register,
// from which the finished pixel is offered. The byte channel accepts a
// transaction every cycle; it stalls only while a finished pixel waits in the
// result register and the byte in the input register would complete another one.
// Write configuration registers only while the block is idle (not enforced).

module bmp_row_to_rgb565_converter_core
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    bmp565_byte_if.sink                         bytes,
    bmp565_pixel_if.source                      pixels,
    input  logic                                cfg_we,
    input  bmp565_pkg::cfg_index_t              cfg_index,
    input  logic [bmp565_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIM_W  = ($clog2(MAX_WIDTH + 1) > bmp565_pkg::ROW_WIDTH_W)
                            ? $clog2(MAX_WIDTH + 1) : bmp565_pkg::ROW_WIDTH_W;
    localparam int CMP_W  = LIM_W + 1;

    // configuration
    bmp565_pkg::pixel_format_t            pixel_format_reg;
    logic [bmp565_pkg::ROW_WIDTH_W-1:0]   row_width_reg;
    logic [1:0]                           pad_bytes_reg;
    logic [15:0]                          masking_color_reg;

    // stream state
    logic [23:0]      byte_gather_reg, byte_gather_next;
    logic [1:0]       byte_phase_reg, byte_phase_next;
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [1:0]       pad_count_reg, pad_count_next;
    logic             in_padding_reg, in_padding_next;

    // input and result registers
    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      pixel_reg;
    logic             row_end_reg;

    logic [2:0]       bytes_per_pixel;
    logic [2:0]       phase_inc;
    logic             pixel_done;
    logic             produces;
    logic             advance;
    logic             last_col;
    logic [1:0]       pad_inc;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] eff_width;
    logic [CMP_W-1:0] column_inc;
    logic [15:0]      packed_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= bmp565_pkg::PIXEL_FORMAT_RESET;
            row_width_reg     <= bmp565_pkg::ROW_WIDTH_RESET;
            pad_bytes_reg     <= bmp565_pkg::PAD_BYTES_RESET;
            masking_color_reg <= bmp565_pkg::MASKING_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmp565_pkg::REG_PIXEL_FORMAT:
                    pixel_format_reg  <= bmp565_pkg::pixel_format_t'(cfg_data[1:0]);
                bmp565_pkg::REG_ROW_WIDTH:
                    row_width_reg     <= cfg_data[bmp565_pkg::ROW_WIDTH_W-1:0];
                bmp565_pkg::REG_PAD_BYTES:
                    pad_bytes_reg     <= cfg_data[1:0];
                bmp565_pkg::REG_MASKING_COLOR:
                    masking_color_reg <= cfg_data[15:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (pixel_format_reg)
            bmp565_pkg::FMT_BGRA32: bytes_per_pixel = 3'd4;
            bmp565_pkg::FMT_BGR24:  bytes_per_pixel = 3'd3;
            default:                bytes_per_pixel = 3'd2;
        endcase
    end

    assign phase_inc  = {1'b0, byte_phase_reg} + 3'd1;
    assign pixel_done = (phase_inc >= bytes_per_pixel);
    assign produces   = !in_padding_reg && pixel_done;
    assign advance    = s1_valid_reg && (!produces || !out_valid_reg || pixels.ready);
    assign bytes.ready = !s1_valid_reg || advance;

    // zero counts as one, anything above the maximum as the maximum
    assign width_ext  = CMP_W'(row_width_reg);
    assign eff_width  = (width_ext == '0) ? CMP_W'(1)
                      : (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
    assign column_inc = CMP_W'(column_count_reg) + CMP_W'(1);
    assign last_col   = (column_inc >= eff_width);
    assign pad_inc    = pad_count_reg + 2'd1;

    bmp565_pixel_pack u_pack
    (
        .pixel_format  (pixel_format_reg),
        .gather        (byte_gather_reg),
        .last_byte     (s1_byte_reg),
        .masking_color (masking_color_reg),
        .pixel         (packed_pixel)
    );

    always_comb
    begin
        byte_gather_next  = byte_gather_reg;
        byte_phase_next   = byte_phase_reg;
        column_count_next = column_count_reg;
        pad_count_next    = pad_count_reg;
        in_padding_next   = in_padding_reg;
        if (advance)
        begin
            if (in_padding_reg)
            begin
                if ((pad_inc == 2'd0) || (pad_inc >= pad_bytes_reg))
                begin
                    in_padding_next = 1'b0;
                    pad_count_next  = 2'd0;
                end
                else
                begin
                    pad_count_next = pad_inc;
                end
            end
            else if (!pixel_done)
            begin
                case (byte_phase_reg)
                    2'd0:    byte_gather_next[7:0]   = byte_gather_reg[7:0]   | s1_byte_reg;
                    2'd1:    byte_gather_next[15:8]  = byte_gather_reg[15:8]  | s1_byte_reg;
                    2'd2:    byte_gather_next[23:16] = byte_gather_reg[23:16] | s1_byte_reg;
                    default: ;
                endcase
                byte_phase_next = phase_inc[1:0];
            end
            else
            begin
                byte_gather_next = '0;
                byte_phase_next  = 2'd0;
                if (last_col)
                begin
                    column_count_next = '0;
                    if (pad_bytes_reg != 2'd0)
                    begin
                        in_padding_next = 1'b1;
                        pad_count_next  = 2'd0;
                    end
                end
                else
                begin
                    column_count_next = column_inc[CNT_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (bytes.ready)
            s1_valid_next = bytes.valid;
        out_valid_next = out_valid_reg;
        if (advance && produces)
            out_valid_next = 1'b1;
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_gather_reg  <= '0;
            byte_phase_reg   <= 2'd0;
            column_count_reg <= '0;
            pad_count_reg    <= 2'd0;
            in_padding_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_gather_reg  <= byte_gather_next;
            byte_phase_reg   <= byte_phase_next;
            column_count_reg <= column_count_next;
            pad_count_reg    <= pad_count_next;
            in_padding_reg   <= in_padding_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
            s1_byte_reg <= bytes.data_byte;
        if (advance && produces)
        begin
            pixel_reg   <= packed_pixel;
            row_end_reg <= last_col;
        end
    end

    assign pixels.valid   = out_valid_reg;
    assign pixels.pixel   = pixel_reg;
    assign pixels.row_end = row_end_reg;

endmodule

FILE: rtl/bmp565_pixel_pack.sv
`timescale 1ns / 1ps

module bmp565_pixel_pack
(
    input  bmp565_pkg::pixel_format_t pixel_format,
    input  logic [23:0]               gather,
    input  logic [7:0]                last_byte,
    input  logic [15:0]               masking_color,
    output logic [15:0]               pixel
);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] word;
    logic [15:0] bgra_pack;
    logic [4:0]  green16;

    assign b0   = gather[7:0];
    assign b1   = gather[15:8];
    assign b2   = gather[23:16];
    assign word = {last_byte, b0};

    assign bgra_pack = {b2[7:3], b1[7:2], b0[7:3]};
    // 16-bit alpha: green low bit flips on a raw match with the masking colour
    assign green16   = word[9:5] ^ {4'd0, (word == masking_color)};

    always_comb
    begin
        case (pixel_format)
            bmp565_pkg::FMT_BGRA32:
            begin
                if (last_byte == 8'd0)
                    pixel = masking_color;
                else if (bgra_pack == masking_color)
                    pixel = bgra_pack ^ bmp565_pkg::GREEN_LSB;
                else
                    pixel = bgra_pack;
            end
            bmp565_pkg::FMT_BGR24:
                pixel = {last_byte[7:3], b1[7:2], b0[7:3]};
            bmp565_pkg::FMT_RGB16_ALPHA:
            begin
                if (!word[15])
                    pixel = masking_color;
                else
                    pixel = {word[14:10], green16, 1'b0, word[4:0]};
            end
            default:
                pixel = word;
        endcase
    end

endmodule

FILE: rtl/bmp565_checker.sv
`timescale 1ns / 1ps

module bmp565_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a stalled pixel stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel transaction withdrawn while stalled");

    // the byte side only stalls behind a waiting pixel
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("byte channel stalled without output backpressure");

    // a new pixel is loaded only on a cycle the byte register moved on
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("pixel appeared while the input stage was blocked");

endmodule

bind bmp_row_to_rgb565_converter_core bmp565_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (bytes.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready)
);

FILE: tb/bmp565_pixel_checker.sv
`timescale 1ns / 1ps

module bmp565_pixel_checker
    import bmp565_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bmp565_byte_if                byte_ch,
    bmp565_pixel_if               pixel_ch,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    n_checked,
    output int                    n_row_end
);

    typedef struct packed {
        logic [15:0] pixel;
        logic        row_end;
    } rgb565_txn_t;

    rgb565_txn_t expected_pixels[$];

    pixel_format_t    fmt_q;
    logic [10:0]      width_q;
    logic [1:0]       pad_q;
    logic [15:0]      mask_q;

    logic [23:0]      gather_q;
    logic [1:0]       phase_q;
    int               col_q;
    logic [1:0]       padcnt_q;
    logic             padding_q;

    function automatic logic [15:0] to_rgb565(pixel_format_t fmt, logic [23:0] gather,
                                              logic [7:0] last, logic [15:0] mask);
        logic [15:0] res;
        logic [15:0] word;
        logic [4:0]  green;
        word = {last, gather[7:0]};
        case (fmt)
            FMT_BGRA32:
            begin
                res = {gather[23:19], gather[15:10], gather[7:3]};
                if (last == 8'h00)
                    res = mask;
                else if (res == mask)
                    res = res ^ GREEN_LSB;
            end
            FMT_BGR24:
                res = {last[7:3], gather[15:10], gather[7:3]};
            FMT_RGB16:
                res = word;
            default:
            begin
                // alpha bit: the top bit is the alpha flag and is dropped by the repack
                green = word[9:5];
                if (word == mask)
                    green = green ^ 5'd1;
                res = word[15] ? {word[14:10], green, 1'b0, word[4:0]} : mask;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        rgb565_txn_t got;
        rgb565_txn_t want;
        int          bpp;
        int          eff;
        logic [1:0]  padcnt_n;
        logic        last_col;
        logic [15:0] pix;
        if (!rst_n)
        begin
            fmt_q      = PIXEL_FORMAT_RESET;
            width_q    = ROW_WIDTH_RESET;
            pad_q      = PAD_BYTES_RESET;
            mask_q     = MASKING_COLOR_RESET;
            gather_q   = '0;
            phase_q    = '0;
            col_q      = 0;
            padcnt_q   = '0;
            padding_q  = 1'b0;
            fail_count = 0;
            n_checked  = 0;
            n_row_end  = 0;
            expected_pixels.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PIXEL_FORMAT:  fmt_q   = pixel_format_t'(cfg_data[1:0]);
                    REG_ROW_WIDTH:     width_q = cfg_data[10:0];
                    REG_PAD_BYTES:     pad_q   = cfg_data[1:0];
                    REG_MASKING_COLOR: mask_q  = cfg_data[15:0];
                    default:           ;
                endcase
            end

            if (pixel_ch.valid && pixel_ch.ready)
            begin
                got.pixel   = pixel_ch.pixel;
                got.row_end = pixel_ch.row_end;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: pixel %h row_end %b with nothing outstanding",
                                 got.pixel, got.row_end);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    n_checked++;
                    if (want.row_end)
                        n_row_end++;
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected pixel %h row_end %b, got %h %b",
                                     want.pixel, want.row_end, got.pixel, got.row_end);
                    end
                end
            end

            if (byte_ch.valid && byte_ch.ready)
            begin
                if (padding_q)
                begin
                    padcnt_n = padcnt_q + 2'd1;
                    if (padcnt_n == 2'd0 || padcnt_n >= pad_q)
                    begin
                        padding_q = 1'b0;
                        padcnt_q  = 2'd0;
                    end
                    else
                        padcnt_q = padcnt_n;
                end
                else
                begin
                    bpp = (fmt_q == FMT_BGRA32) ? 4 : (fmt_q == FMT_BGR24) ? 3 : 2;
                    if (int'(phase_q) + 1 < bpp)
                    begin
                        gather_q = gather_q | (24'(byte_ch.data_byte) << (8 * phase_q));
                        phase_q  = phase_q + 2'd1;
                    end
                    else
                    begin
                        pix      = to_rgb565(fmt_q, gather_q, byte_ch.data_byte, mask_q);
                        gather_q = '0;
                        phase_q  = '0;
                        if (width_q == 11'd0)
                            eff = 1;
                        else if (int'(width_q) > MAX_WIDTH)
                            eff = MAX_WIDTH;
                        else
                            eff = int'(width_q);
                        last_col = (col_q + 1 >= eff);
                        if (last_col)
                        begin
                            col_q = 0;
                            if (pad_q != 2'd0)
                            begin
                                padding_q = 1'b1;
                                padcnt_q  = 2'd0;
                            end
                        end
                        else
                            col_q++;
                        want.pixel   = pix;
                        want.row_end = last_col;
                        expected_pixels.push_back(want);
                    end
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bmp565_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 6;
    localparam int BIG_PHASE    = 4;
    localparam int BIG_PIXELS   = 60;
    localparam int HOLD_PHASE   = 7;
    localparam int HOLD_LEN     = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int n_checked;
    int n_row_end;

    bmp565_byte_if  byte_ch ();
    bmp565_pixel_if pixel_ch ();

    bmp_row_to_rgb565_converter_core #(.MAX_WIDTH(MAX_WIDTH)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .pixels    (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmp565_pixel_checker #(.MAX_WIDTH(MAX_WIDTH)) u_pixel_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .pixel_ch   (pixel_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .n_checked  (n_checked),
        .n_row_end  (n_row_end)
    );

    // stimulus-side copy of the registers, used to shape whole pixels and rows
    pixel_format_t fmt_s;
    logic [10:0]   width_s;
    logic [1:0]    pad_s;
    logic [15:0]   mask_s;
    int            col_s;

    int            sent_items;
    int            phase_no;
    int            burst_left;
    logic          hold_req;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // receiver: stall pattern of its own, plus one long hold-off
    initial
    begin : pixel_sink
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        logic hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                pixel_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       pixel_ch.ready <= 1'b1;
                    1:       pixel_ch.ready <= 1'($urandom_range(0, 1));
                    2:       pixel_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: pixel_ch.ready <= tick[2];
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                byte_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sent_items++;
    endtask

    // wait until every expected pixel is out and the pipeline has emptied
    task automatic settle();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT:  fmt_s   = pixel_format_t'(value[1:0]);
            REG_ROW_WIDTH:     width_s = value[10:0];
            REG_PAD_BYTES:     pad_s   = value[1:0];
            REG_MASKING_COLOR: mask_s  = value;
            default:           ;
        endcase
    endtask

    // one whole pixel of the current format, then the row filler if the row ends
    task automatic send_pixel();
        logic [7:0]  px [4];
        logic [15:0] word;
        int          nbytes;
        int          sel;
        int          eff;
        sel = $urandom_range(0, 7);
        for (int i = 0; i < 4; i++)
        begin
            px[i] = 8'($urandom);
            if (sel == 7)
                px[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        case (fmt_s)
            FMT_BGRA32:
            begin
                nbytes = 4;
                if (sel == 0)
                    px[3] = 8'h00;
                else if (sel == 1)
                begin
                    px[0] = {mask_s[4:0], px[0][2:0]};
                    px[1] = {mask_s[10:5], px[1][1:0]};
                    px[2] = {mask_s[15:11], px[2][2:0]};
                    px[3] = 8'($urandom_range(1, 255));
                end
            end
            FMT_BGR24:
                nbytes = 3;
            default:
            begin
                nbytes = 2;
                word   = {px[1], px[0]};
                if (fmt_s == FMT_RGB16_ALPHA)
                begin
                    if (sel == 0 || sel == 1)
                        word = mask_s;
                    else if (sel == 2)
                        word[15] = 1'b0;
                end
                px[0] = word[7:0];
                px[1] = word[15:8];
            end
        endcase
        for (int i = 0; i < nbytes; i++)
            send_byte(px[i]);
        if (width_s == 11'd0)
            eff = 1;
        else if (int'(width_s) > MAX_WIDTH)
            eff = MAX_WIDTH;
        else
            eff = int'(width_s);
        if (col_s + 1 >= eff)
        begin
            col_s = 0;
            repeat (pad_s)
                send_byte(8'($urandom));
        end
        else
            col_s++;
    endtask

    initial
    begin : stimulus
        int          stop_at;
        int          broken_from;
        int          npix;
        int          r;
        logic        wr_fmt;
        logic        wr_width;
        logic        wr_pad;
        logic        wr_mask;
        logic [15:0] new_width;
        logic [15:0] new_mask;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_PIXEL_FORMAT;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        fmt_s             = PIXEL_FORMAT_RESET;
        width_s           = ROW_WIDTH_RESET;
        pad_s             = PAD_BYTES_RESET;
        mask_s            = MASKING_COLOR_RESET;
        col_s             = 0;
        sent_items        = 0;
        phase_no          = 0;
        burst_left        = 0;
        hold_req          = 1'b0;

        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // 32-bit: colour key hit, zero alpha; zero width gives one-pixel rows
        write_reg(REG_PIXEL_FORMAT, 16'(FMT_BGRA32));
        write_reg(REG_ROW_WIDTH, 16'd0);
        write_reg(REG_PAD_BYTES, 16'd1);
        write_reg(REG_MASKING_COLOR, 16'hFFFF);
        repeat (4)
            send_byte(8'hFF);
        send_byte(8'h5A);
        repeat (4)
            send_byte(8'h00);
        send_byte(8'hA5);
        settle();

        // 16-bit alpha: raw word equals key, alpha clear, all ones; width clamped
        write_reg(REG_PIXEL_FORMAT, 16'(FMT_RGB16_ALPHA));
        write_reg(REG_ROW_WIDTH, 16'd2047);
        write_reg(REG_PAD_BYTES, 16'd0);
        write_reg(REG_MASKING_COLOR, 16'h8000);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();

        // width cut below the current column mid-row
        write_reg(REG_PIXEL_FORMAT, 16'(FMT_RGB16));
        write_reg(REG_ROW_WIDTH, 16'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        write_reg(REG_PIXEL_FORMAT, 16'(FMT_BGR24));
        write_reg(REG_PAD_BYTES, 16'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'hC3);

        // format change with half a pixel gathered
        send_byte(8'hAA);
        settle();
        write_reg(REG_PIXEL_FORMAT, 16'(FMT_RGB16));
        send_byte(8'h55);
        send_byte(8'h0F);
        send_byte(8'hF0);
        col_s = 0;

        stop_at     = sent_items + RANDOM_ITEMS;
        broken_from = stop_at - RANDOM_ITEMS / 6;
        while (sent_items < stop_at)
        begin
            phase_no++;
            if (phase_no == BIG_PHASE)
            begin
                // a long stretch of pixels at the clamped width
                settle();
                write_reg(REG_PIXEL_FORMAT, 16'(FMT_RGB16));
                write_reg(REG_ROW_WIDTH, 16'd2047);
                write_reg(REG_PAD_BYTES, 16'd3);
                repeat (BIG_PIXELS)
                    send_pixel();
            end
            else
            begin
                wr_fmt   = ($urandom_range(0, 1) == 0);
                wr_width = ($urandom_range(0, 2) == 0);
                wr_pad   = ($urandom_range(0, 2) == 0);
                wr_mask  = ($urandom_range(0, 2) == 0);
                r = $urandom_range(0, 15);
                case (r)
                    0:       new_width = 16'd0;
                    1:       new_width = 16'd1;
                    2:       new_width = 16'd1024;
                    3:       new_width = 16'($urandom_range(1025, 2047));
                    4, 5:    new_width = 16'($urandom_range(7, 40));
                    default: new_width = 16'($urandom_range(2, 6));
                endcase
                r = $urandom_range(0, 7);
                case (r)
                    0:       new_mask = 16'h0000;
                    1:       new_mask = 16'hFFFF;
                    2, 3:    new_mask = 16'($urandom) | 16'h8000;
                    default: new_mask = 16'($urandom);
                endcase
                if (wr_fmt || wr_width || wr_pad || wr_mask)
                    settle();
                if (wr_fmt)
                    write_reg(REG_PIXEL_FORMAT, 16'($urandom_range(0, 3)));
                if (wr_width)
                    write_reg(REG_ROW_WIDTH, new_width);
                if (wr_pad)
                    write_reg(REG_PAD_BYTES, 16'($urandom_range(0, 3)));
                if (wr_mask)
                    write_reg(REG_MASKING_COLOR, new_mask);
                npix = $urandom_range(1, 24);
                if (phase_no == HOLD_PHASE)
                begin
                    npix     = 40;
                    hold_req = 1'b1;
                end
                repeat (npix)
                    send_pixel();
                // stray bytes: pixels and rows fall out of step from here on
                if (sent_items >= broken_from && $urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom));
            end
        end
        settle();

        $display("summary: %0d bytes over %0d register phases, all four formats",
                 sent_items, phase_no);
        $display("summary: %0d pixels checked, %0d of them closing a row",
                 n_checked, n_row_end);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
